/* sv/stpq_pkg.sv */
// Package: request and response words, entry layout and codes for the task queue.
package stpq_pkg;

	localparam int DEPTH_DEF = 16;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_POP    = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] task_id;
		logic [31:0] job_key;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] out_task_id;
		logic [31:0] out_key;
		logic [4:0]  occupancy;
	} rsp_t;

	typedef struct packed {
		logic [15:0] id;
		logic [31:0] key;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

/* sv/sorted_task_priority_queue.sv */
// Sorted task queue: one request word in, one response word out, entries in one RAM.
// Insert walks down from the last entry, moving each entry with a larger key up one slot, then writes
// the new entry; an empty queue takes it in slot 0 directly, a full queue answers ST_FULL. Pop and remove
// scan from slot 0 (pop takes slot 0), then shift later entries down. Only one request is taken at a time.
// Reset clears the entry count and control; RAM contents are left as they are.
module sorted_task_priority_queue #(
	parameter int DEPTH = stpq_pkg::DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  stpq_pkg::req_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output stpq_pkg::rsp_t  out_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_INS      = 6'b000010,
		S_INS_HEAD = 6'b000100,
		S_SRCH     = 6'b001000,
		S_SHF      = 6'b010000,
		S_RESP     = 6'b100000
	} state_t;

	state_t           state_q;
	stpq_pkg::req_t   req_q;
	stpq_pkg::rsp_t   res_q;
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    idx_q;
	logic             out_valid_q;
	stpq_pkg::rsp_t   out_q;

	logic                      we, re;
	logic [AW-1:0]             waddr, raddr;
	stpq_pkg::entry_t          wdata, rdata;
	logic [stpq_pkg::ENTRY_W-1:0] rdata_raw;

	logic [CW-1:0] idx_next;
	logic          more;
	logic          match;

	assign rdata    = stpq_pkg::entry_t'(rdata_raw);
	assign idx_next = CW'(idx_q) + CW'(1);
	assign more     = idx_next < count_q;
	assign match    = (req_q.req_type == stpq_pkg::REQ_POP) || (rdata.id == req_q.task_id);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	stpq_ram #(
		.WIDTH(stpq_pkg::ENTRY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata_raw)
	);

	// drive RAM ports from the current step of the walk
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		re    = 1'b0;
		raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_data.req_type == stpq_pkg::REQ_INSERT) begin
						if (count_q == CW'(0)) begin
							we    = 1'b1;
							waddr = '0;
							wdata = '{id: in_data.task_id, key: in_data.job_key};
						end else if (count_q != CW'(DEPTH)) begin
							re    = 1'b1;
							raddr = AW'(count_q - CW'(1));
						end
					end else begin
						re    = 1'b1;
						raddr = '0;
					end
				end
			end
			S_INS: begin
				we = 1'b1;
				if (rdata.key > req_q.job_key) begin
					waddr = AW'(idx_next);
					wdata = rdata;
					if (idx_q != '0) begin
						re    = 1'b1;
						raddr = idx_q - AW'(1);
					end
				end else begin
					waddr = AW'(idx_next);
					wdata = '{id: req_q.task_id, key: req_q.job_key};
				end
			end
			S_INS_HEAD: begin
				we    = 1'b1;
				waddr = '0;
				wdata = '{id: req_q.task_id, key: req_q.job_key};
			end
			S_SRCH: begin
				if (more) begin
					re    = 1'b1;
					raddr = AW'(idx_next);
				end
			end
			S_SHF: begin
				we    = 1'b1;
				waddr = idx_q - AW'(1);
				wdata = rdata;
				if (more) begin
					re    = 1'b1;
					raddr = AW'(idx_next);
				end
			end
			default: begin
			end
		endcase
	end

	// sequence one request through the RAM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (in_data.req_type)
							stpq_pkg::REQ_INSERT: begin
								if (count_q == CW'(DEPTH)) begin
									res_q   <= '{status: stpq_pkg::ST_FULL, out_task_id: '0,
										out_key: '0, occupancy: 5'(count_q)};
									state_q <= S_RESP;
								end else if (count_q == CW'(0)) begin
									count_q <= CW'(1);
									res_q   <= '{status: stpq_pkg::ST_OK, out_task_id: '0,
										out_key: '0, occupancy: 5'd1};
									state_q <= S_RESP;
								end else begin
									res_q   <= '{status: stpq_pkg::ST_MISS, out_task_id: '0,
										out_key: '0, occupancy: 5'(count_q)};
									idx_q   <= AW'(count_q - CW'(1));
									state_q <= S_INS;
								end
							end
							stpq_pkg::REQ_POP, stpq_pkg::REQ_REMOVE: begin
								res_q   <= '{status: stpq_pkg::ST_MISS, out_task_id: '0,
									out_key: '0, occupancy: 5'(count_q)};
								idx_q   <= '0;
								state_q <= (count_q == CW'(0)) ? S_RESP : S_SRCH;
							end
							default: begin
								res_q   <= '{status: stpq_pkg::ST_MISS, out_task_id: '0,
									out_key: '0, occupancy: 5'(count_q)};
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_INS: begin
					if ((rdata.key > req_q.job_key) && (idx_q != '0)) begin
						idx_q <= idx_q - AW'(1);
					end else begin
						if (rdata.key > req_q.job_key) begin
							state_q <= S_INS_HEAD;
						end else begin
							state_q <= S_RESP;
						end
						count_q         <= count_q + CW'(1);
						res_q.status    <= stpq_pkg::ST_OK;
						res_q.occupancy <= 5'(count_q + CW'(1));
					end
				end
				S_INS_HEAD: begin
					state_q <= S_RESP;
				end
				S_SRCH: begin
					if (match) begin
						res_q.status      <= stpq_pkg::ST_OK;
						res_q.out_task_id <= rdata.id;
						res_q.out_key     <= rdata.key;
						res_q.occupancy   <= 5'(count_q - CW'(1));
						if (more) begin
							idx_q   <= AW'(idx_next);
							state_q <= S_SHF;
						end else begin
							count_q <= count_q - CW'(1);
							state_q <= S_RESP;
						end
					end else if (more) begin
						idx_q <= AW'(idx_next);
					end else begin
						state_q <= S_RESP;
					end
				end
				S_SHF: begin
					if (more) begin
						idx_q <= AW'(idx_next);
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// hold the request word and load the output word
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q <= in_data;
		end
		if (state_q == S_RESP && (!out_valid_q || out_ready)) begin
			out_q <= res_q;
		end
	end

endmodule

/* sv/stpq_ram.sv */
// Generic simple dual-port RAM with registered read.
module stpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
